[rtl/core/round_robin_task_scheduler_core_macros.svh]
// ----------------------------------------------------------------------------
// round-robin task scheduler assertion macros
// shared property forms, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_MACROS_SVH

// condition holds at every edge
`define RRTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds on the edge after the antecedent
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rrts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// types and constants of the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W    = 8;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 16;
  localparam int SLICE_W = 8;

  localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd4;

  // input kind
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  // result kind
  localparam logic EVT_DONE   = 1'b0;
  localparam logic EVT_REJECT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [LEN_W-1:0]  remaining;
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  burst_length;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT_WB,
    ST_RUN_RD,
    ST_RUN_WB,
    ST_REJECT
  } state_t;

endpackage

[rtl/core/rrts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/round_robin_task_scheduler_core.sv]
`timescale 1ns / 1ps
// Round-robin time-slice scheduler. Tasks sit in a circular queue held in one
// RAM with a registered read; head, tail, count, time and slice counters are
// registers. Items are handled one at a time: an arrival is written to the
// tail of the queue, or, when the queue is full, produces a reject item; a
// tick with an empty queue only advances time; a tick that runs the head task
// reads it, then writes it back or completes it, and the head task may first
// be rotated to the tail, which costs an extra read and write of the RAM.
// A result waiting on the output does not block the next item; the block only
// stalls when a new result is ready and the previous one has not been taken.
// The quantum register may be written whenever the block is idle.
`include "round_robin_task_scheduler_core_macros.svh"
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core
// top level: stream in/out, quantum register, queue control around the ram
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // task_id [7:0], burst_length [23:8]
  input  logic        in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // done_task_id [7:0], turnaround [23:8], waiting [39:24]
  output logic        out_tuser,  // event_kind [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // quantum [7:0]
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  rrts_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [rrts_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic [rrts_pkg::SLICE_W-1:0] slice_r, slice_nxt;
  logic [rrts_pkg::SLICE_W-1:0] quantum_r;
  logic [rrts_pkg::ID_W-1:0]    rej_id_r, rej_id_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic [39:0] out_tdata_r, out_tdata_nxt;

  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr;
  rrts_pkg::entry_t wr_entry, rd_entry;
  logic [$bits(rrts_pkg::entry_t)-1:0] rd_word;

  logic                        in_fire, out_free, finish_fire;
  logic [rrts_pkg::ID_W-1:0]   in_id;
  logic [rrts_pkg::LEN_W-1:0]  in_burst;
  logic [rrts_pkg::TIME_W-1:0] time_inc, tat, wt;

  assign in_id    = in_tdata[7:0];
  assign in_burst = in_tdata[23:8];
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign rd_entry = rrts_pkg::entry_t'(rd_word);
  assign time_inc = time_r + rrts_pkg::TIME_W'(1);
  assign tat      = time_inc - rd_entry.arrival;
  assign wt       = tat - rd_entry.burst_length;
  assign cfg_ready = 1'b1;

  rrts_ram #(
    .WIDTH($bits(rrts_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(head_r),
    .rd_data(rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rrts_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      time_r       <= '0;
      slice_r      <= '0;
      quantum_r    <= rrts_pkg::QUANTUM_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      time_r       <= time_nxt;
      slice_r      <= slice_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rej_id_r    <= rej_id_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    time_nxt       = time_r;
    slice_nxt      = slice_r;
    rej_id_nxt     = rej_id_r;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = (state_r == rrts_pkg::ST_IDLE);
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    wr_entry       = rd_entry;
    rd_en          = 1'b0;
    finish_fire    = 1'b0;

    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == rrts_pkg::CMD_ARRIVE) begin
            if (count_r == CNT_FULL) begin
              rej_id_nxt = in_id;
              state_nxt  = rrts_pkg::ST_REJECT;
            end else begin
              wr_en                 = 1'b1;
              wr_entry.task_id      = in_id;
              wr_entry.remaining    = in_burst;
              wr_entry.arrival      = time_r;
              wr_entry.burst_length = in_burst;
              tail_nxt              = ptr_inc(tail_r);
              count_nxt             = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            time_nxt = time_inc;
          end else begin
            rd_en     = 1'b1;
            state_nxt = (slice_r >= quantum_r) ? rrts_pkg::ST_ROT_WB : rrts_pkg::ST_RUN_WB;
          end
        end
      end
      rrts_pkg::ST_ROT_WB: begin
        // move head entry to the tail
        wr_en     = 1'b1;
        wr_addr   = tail_r;
        wr_entry  = rd_entry;
        head_nxt  = ptr_inc(head_r);
        tail_nxt  = ptr_inc(tail_r);
        slice_nxt = '0;
        state_nxt = rrts_pkg::ST_RUN_RD;
      end
      rrts_pkg::ST_RUN_RD: begin
        rd_en     = 1'b1;
        state_nxt = rrts_pkg::ST_RUN_WB;
      end
      rrts_pkg::ST_RUN_WB: begin
        if (rd_entry.remaining <= rrts_pkg::LEN_W'(1)) begin
          if (out_free) begin
            finish_fire    = 1'b1;
            out_tvalid_nxt = 1'b1;
            out_tuser_nxt  = rrts_pkg::EVT_DONE;
            out_tdata_nxt  = {wt, tat, rd_entry.task_id};
            head_nxt       = ptr_inc(head_r);
            count_nxt      = count_r - CNT_W'(1);
            slice_nxt      = '0;
            time_nxt       = time_inc;
            state_nxt      = rrts_pkg::ST_IDLE;
          end
        end else begin
          wr_en              = 1'b1;
          wr_addr            = head_r;
          wr_entry           = rd_entry;
          wr_entry.remaining = rd_entry.remaining - rrts_pkg::LEN_W'(1);
          time_nxt           = time_inc;
          slice_nxt          = slice_r + rrts_pkg::SLICE_W'(1);
          state_nxt          = rrts_pkg::ST_IDLE;
        end
      end
      rrts_pkg::ST_REJECT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = rrts_pkg::EVT_REJECT;
          out_tdata_nxt  = {32'd0, rej_id_r};
          state_nxt      = rrts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  `RRTS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_FULL, "task count above queue depth")
  `RRTS_ASSERT_ALWAYS(a_empty_ptrs, (count_r != '0) || (head_r == tail_r),
                      "empty queue with head and tail apart")
  `RRTS_ASSERT_ALWAYS(a_reject_full, (state_r != rrts_pkg::ST_REJECT) || (count_r == CNT_FULL),
                      "reject without a full queue")
  `RRTS_ASSERT_NEXT(a_finish_pop, finish_fire, count_r == $past(count_r) - CNT_W'(1),
                    "completion did not remove a task")

endmodule
